>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DRAS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DRAS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dras_pkg.sv
// Shared types and constants for the deferred reuse slot allocator.
// No dependencies.
package dras_pkg;

    localparam int KEY_W    = 48;
    localparam int FRAME_W  = 32;
    localparam int SLOT_W   = 8;
    localparam int STATUS_W = 3;

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_FORGET = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT         = 3'd0,
        ST_FRESH       = 3'd1,
        ST_REUSED      = 3'd2,
        ST_FULL        = 3'd3,
        ST_FORGOTTEN   = 3'd4,
        ST_FORGET_MISS = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_UPDATE,
        S_REPLY
    } state_t;

    // One slot record: bound key (0 = none) and free stamp (0 = never freed).
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [FRAME_W-1:0] freed;
    } slot_entry_t;

endpackage

>>> rtl/dras_req_if.sv
// Request channel: valid/ready handshake carrying command, key and frame.
// Depends on dras_pkg.
interface dras_req_if
    import dras_pkg::*;
();
    logic                 valid;
    logic                 ready;
    cmd_t                 command;
    logic [KEY_W-1:0]     key;
    logic [FRAME_W-1:0]   frame;

    modport source (output valid, output command, output key, output frame, input ready);
    modport sink   (input valid, input command, input key, input frame, output ready);
endinterface

>>> rtl/dras_rsp_if.sv
// Response channel: valid/ready handshake carrying slot and status.
// Depends on dras_pkg.
interface dras_rsp_if
    import dras_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   slot;
    status_t             status;

    modport source (output valid, output slot, output status, input ready);
    modport sink   (input valid, input slot, input status, output ready);
endinterface

>>> rtl/deferred_reuse_slot_allocator.sv
// Deferred reuse slot allocator: maps keys to slots held in one synchronous RAM.
// Depends on dras_pkg, dras_req_if, dras_rsp_if.
// The RAM scan reads one slot per cycle over the slots handed out so far (the fill
// count, up to HEAP_SLOTS); the scan is skipped when none are. One request is worked
// at a time; a new request is taken while the last response waits. Reset clears
// control and the fill count; the RAM is not cleared, slots at or above the fill
// count are never read.
module deferred_reuse_slot_allocator
    import dras_pkg::*;
#(
    parameter int HEAP_SLOTS       = 256,
    parameter int FRAMES_IN_FLIGHT = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    dras_req_if.sink   req,
    dras_rsp_if.source rsp
);

    localparam int IDX_W = (HEAP_SLOTS > 1) ? $clog2(HEAP_SLOTS) : 1;
    localparam int CNT_W = $clog2(HEAP_SLOTS + 1);
    localparam logic [FRAME_W-1:0] AGE_MIN = FRAME_W'(FRAMES_IN_FLIGHT + 1);
    localparam logic [CNT_W-1:0]   FILL_MAX = CNT_W'(HEAP_SLOTS);

    // Slot RAM
    slot_entry_t mem [HEAP_SLOTS];

    state_t             state_reg, state_next;
    cmd_t               cmd_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [IDX_W-1:0]   addr_reg, addr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    slot_entry_t        rd_data_reg;
    logic               hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic               reuse_found_reg, reuse_found_next;
    logic [IDX_W-1:0]   reuse_idx_reg, reuse_idx_next;
    logic [IDX_W-1:0]   res_idx_reg, res_idx_next;
    status_t            res_status_reg, res_status_next;
    logic               out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]  out_slot_reg;
    status_t            out_status_reg;

    logic               accept;
    logic               rd_en;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    slot_entry_t        wr_data;
    logic               key_match;
    logic               reusable;
    logic [FRAME_W-1:0] age;
    logic               load_out;

    assign accept   = req.valid && req.ready;
    assign rd_en    = (state_reg == S_SCAN);
    assign load_out = (state_reg == S_REPLY) && (!out_valid_reg || rsp.ready);

    assign age       = frame_reg - rd_data_reg.freed;
    assign key_match = rd_vld_reg && (key_reg != '0) && (rd_data_reg.key == key_reg);
    assign reusable  = rd_vld_reg && (rd_data_reg.key == '0) && (rd_data_reg.freed != '0)
                       && (age > AGE_MIN);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (fill_reg == '0) ? S_UPDATE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (addr_reg == IDX_W'(fill_reg - 1'b1))
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:   state_next = S_UPDATE;
            S_UPDATE: state_next = S_REPLY;
            S_REPLY:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        addr_next        = addr_reg;
        fill_next        = fill_reg;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        reuse_found_next = reuse_found_reg;
        reuse_idx_next   = reuse_idx_reg;
        res_idx_next     = res_idx_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                addr_next        = '0;
                hit_found_next   = 1'b0;
                reuse_found_next = 1'b0;
            end
            S_SCAN, S_LAST:
            begin
                if (state_reg == S_SCAN)
                begin
                    addr_next = addr_reg + 1'b1;
                end
                if (key_match && !hit_found_reg)
                begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = rd_idx_reg;
                end
                if (reusable && !reuse_found_reg)
                begin
                    reuse_found_next = 1'b1;
                    reuse_idx_next   = rd_idx_reg;
                end
            end
            S_UPDATE:
            begin
                res_idx_next = '0;
                if (cmd_reg == CMD_FORGET)
                begin
                    if (hit_found_reg)
                    begin
                        wr_en           = 1'b1;
                        wr_addr         = hit_idx_reg;
                        wr_data.key     = '0;
                        wr_data.freed   = frame_reg | FRAME_W'(1);
                        res_idx_next    = hit_idx_reg;
                        res_status_next = ST_FORGOTTEN;
                    end
                    else
                    begin
                        res_status_next = ST_FORGET_MISS;
                    end
                end
                else if (hit_found_reg)
                begin
                    res_idx_next    = hit_idx_reg;
                    res_status_next = ST_HIT;
                end
                else if (key_reg == '0)
                begin
                    res_status_next = ST_FULL;
                end
                else if (fill_reg != FILL_MAX)
                begin
                    wr_en           = 1'b1;
                    wr_addr         = IDX_W'(fill_reg);
                    wr_data.key     = key_reg;
                    wr_data.freed   = '0;
                    fill_next       = fill_reg + 1'b1;
                    res_idx_next    = IDX_W'(fill_reg);
                    res_status_next = ST_FRESH;
                end
                else if (reuse_found_reg)
                begin
                    wr_en           = 1'b1;
                    wr_addr         = reuse_idx_reg;
                    wr_data.key     = key_reg;
                    wr_data.freed   = '0;
                    res_idx_next    = reuse_idx_reg;
                    res_status_next = ST_REUSED;
                end
                else
                begin
                    res_status_next = ST_FULL;
                end
            end
            S_REPLY:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            addr_reg        <= '0;
            fill_reg        <= '0;
            rd_vld_reg      <= 1'b0;
            hit_found_reg   <= 1'b0;
            reuse_found_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            addr_reg        <= addr_next;
            fill_reg        <= fill_next;
            rd_vld_reg      <= rd_en;
            hit_found_reg   <= hit_found_next;
            reuse_found_reg <= reuse_found_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= req.command;
            key_reg   <= req.key;
            frame_reg <= req.frame;
        end
        rd_idx_reg     <= addr_reg;
        hit_idx_reg    <= hit_idx_next;
        reuse_idx_reg  <= reuse_idx_next;
        res_idx_reg    <= res_idx_next;
        res_status_reg <= res_status_next;
        if (load_out)
        begin
            out_slot_reg   <= SLOT_W'(res_idx_reg);
            out_status_reg <= res_status_reg;
        end
    end

    // Slot RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.slot   = out_slot_reg;
    assign rsp.status = out_status_reg;

endmodule

>>> rtl/dras_checker.sv
// Port-level checks for deferred_reuse_slot_allocator, attached by bind.
// Depends on dras_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dras_checker
    import dras_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [SLOT_W-1:0] rsp_slot,
    input status_t           rsp_status
);

    // One request in flight: ready drops right after a request is taken.
    `DRAS_ASSERT_NXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready, "request taken while busy")

    // No slot index is reported for full or forget miss.
    `DRAS_ASSERT_NOW(a_none_slot_zero, clk, rst_n, rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_FORGET_MISS), rsp_slot == '0, "nonzero slot on full or forget miss")

    // Stalled response stays put.
    `DRAS_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_slot) && $stable(rsp_status), "response changed while stalled")

    // A new response only appears after a request was taken while idle.
    `DRAS_ASSERT_NXT(a_rsp_needs_req, clk, rst_n, req_ready && !(req_valid && req_ready), !$rose(rsp_valid), "response without request")

endmodule

bind deferred_reuse_slot_allocator dras_checker u_dras_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_slot   (rsp.slot),
    .rsp_status (rsp.status)
);
